FILE: design/sla_pkg.sv
// ----------------------------------------------------------------------------
// Serial line assembler package
// Shared types and character codes for the line assembler.
// ----------------------------------------------------------------------------
package sla_pkg;

    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_LF  = 8'h0A;
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_DEL = 8'h7F;

    localparam logic [1:0] ADDR_LINE_ENABLE  = 2'd0;
    localparam logic       LINE_ENABLE_RESET = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_LOAD,
        ST_HOLD
    } state_t;

    typedef struct packed {
        logic append;
        logic remove;
        logic start;
        logic read;
        logic load;
        logic clear;
    } cmd_t;

    typedef struct packed {
        logic is_term;
        logic is_del;
        logic empty;
        logic full;
        logic last;
    } status_t;

endpackage

FILE: design/sla_ram.sv
// ----------------------------------------------------------------------------
// Line store RAM
// Single write port, single read port with registered read data.
// ----------------------------------------------------------------------------
module sla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: design/sla_ctrl.sv
// ----------------------------------------------------------------------------
// Line assembler controller
// Sequences byte intake and the read-out of a completed line.
// ----------------------------------------------------------------------------
module sla_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             line_enable,
    input  logic             in_valid,
    output logic             in_ready,
    output logic             out_valid,
    input  logic             out_ready,
    input  sla_pkg::status_t status,
    output sla_pkg::cmd_t    cmd
);

    import sla_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid && line_enable)
                begin
                    if (status.is_term)
                    begin
                        if (!status.empty)
                        begin
                            cmd.start  = 1'b1;
                            state_next = ST_FETCH;
                        end
                    end
                    else if (status.is_del)
                    begin
                        cmd.remove = !status.empty;
                    end
                    else
                    begin
                        cmd.append = !status.full;
                    end
                end
            end
            ST_FETCH:
            begin
                cmd.read   = 1'b1;
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                cmd.load   = 1'b1;
                state_next = ST_HOLD;
            end
            ST_HOLD:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    if (status.last)
                    begin
                        cmd.clear  = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FETCH;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: design/sla_dp.sv
// ----------------------------------------------------------------------------
// Line assembler datapath
// Fill count, read index, line store and output register.
// ----------------------------------------------------------------------------
module sla_dp #(
    parameter int LINE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       rx_byte,
    input  sla_pkg::cmd_t    cmd,
    output sla_pkg::status_t status,
    output logic [7:0]       line_byte,
    output logic [5:0]       line_length,
    output logic             is_last
);

    import sla_pkg::*;

    localparam int FILL_W = $clog2(LINE_DEPTH);
    localparam logic [FILL_W-1:0] FILL_MAX = FILL_W'(LINE_DEPTH - 1);
    localparam logic [FILL_W-1:0] FILL_ONE = FILL_W'(1);

    logic [FILL_W-1:0]   fill_reg;
    logic [FILL_W-1:0]   fill_next;
    logic [FILL_W-1:0]   idx_reg;
    logic [FILL_W-1:0]   idx_next;
    logic [FILL_W-1:0]   idx_inc;
    logic [7:0]          byte_reg;
    logic                last_reg;
    logic [7:0]          rdata;
    logic [FILL_W+5:0]   len_ext;

    assign idx_inc = idx_reg + FILL_ONE;

    always_comb
    begin
        fill_next = fill_reg;
        if (cmd.append)
        begin
            fill_next = fill_reg + FILL_ONE;
        end
        else if (cmd.remove)
        begin
            fill_next = fill_reg - FILL_ONE;
        end
        else if (cmd.clear)
        begin
            fill_next = '0;
        end
    end

    always_comb
    begin
        idx_next = idx_reg;
        if (cmd.start)
        begin
            idx_next = '0;
        end
        else if (cmd.load)
        begin
            idx_next = idx_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            idx_reg  <= '0;
            last_reg <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            idx_reg  <= idx_next;
            if (cmd.load)
            begin
                last_reg <= (idx_inc == fill_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            byte_reg <= rdata;
        end
    end

    sla_ram #(
        .WIDTH (8),
        .DEPTH (LINE_DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (cmd.append),
        .waddr (fill_reg),
        .wdata (rx_byte),
        .re    (cmd.read),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    assign status.is_term = (rx_byte == CH_CR) || (rx_byte == CH_LF);
    assign status.is_del  = (rx_byte == CH_BS) || (rx_byte == CH_DEL);
    assign status.empty   = (fill_reg == '0);
    assign status.full    = (fill_reg >= FILL_MAX);
    assign status.last    = last_reg;

    assign len_ext     = {6'd0, fill_reg};
    assign line_length = len_ext[5:0];
    assign line_byte   = byte_reg;
    assign is_last     = last_reg;

endmodule

FILE: design/serial_line_assembler_unit.sv
// ----------------------------------------------------------------------------
// Serial line assembler
// Builds text lines from received bytes, with backspace and delete editing.
//
// Input channel: one rx_byte per transfer. CR or LF ends the line; BS and DEL
// remove the last stored byte; other bytes are stored until the line holds
// LINE_DEPTH - 1 bytes, after which they are dropped. With line_enable at 0
// every byte is taken and ignored.
// Output channel: a completed non-empty line leaves as one transfer per byte,
// each carrying line_length, with is_last on the final byte.
// Timing: ordinary bytes are taken while the block idles. After a terminator
// the block takes no input until the line has left; each byte of the line
// goes through a store read, an output load and a transfer, and is held while
// out_ready is low. Bytes are read through the line store's single read port.
// Reset: the line is emptied and line_enable returns to 1; no clearing pass.
// Configuration: line_enable at byte address 0 (every write reaches it), to be
// written only while the block idles; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module serial_line_assembler_unit #(
    parameter int LINE_DEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  line_byte,
    output logic [5:0]  line_length,
    output logic        is_last
);

    import sla_pkg::*;

    logic    line_enable_reg;
    cmd_t    cmd;
    status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_enable_reg <= LINE_ENABLE_RESET;
        end
        else if (psel && penable && pwrite)
        begin
            line_enable_reg <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_LINE_ENABLE) ? {31'd0, line_enable_reg} : 32'd0;

    sla_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .line_enable (line_enable_reg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .cmd         (cmd)
    );

    sla_dp #(
        .LINE_DEPTH (LINE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .rx_byte     (rx_byte),
        .cmd         (cmd),
        .status      (status),
        .line_byte   (line_byte),
        .line_length (line_length),
        .is_last     (is_last)
    );

endmodule

FILE: tb/tb_serial_line_assembler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Serial line assembler testbench
// Feeds received bytes through the input channel and checks every character
// of each completed line against a line-editing predictor kept in step with
// the block. Covers empty lines, backspace and delete, line overflow,
// disabled assembly, long receiver hold-offs and random sender and receiver
// idling.
// ----------------------------------------------------------------------------
module tb_serial_line_assembler_unit;
    import sla_pkg::*;

    localparam int LINE_DEPTH     = 64;
    localparam int HOLD_LEN       = 300;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_ITEMS   = 48;

    typedef struct packed {
        logic [7:0] ch;
        logic [5:0] len;
        logic       last;
    } line_char_t;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PATTERN
    } ready_mode_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [1:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    logic [7:0]  rx_byte   = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [7:0]  line_byte;
    logic [5:0]  line_length;
    logic        is_last;

    line_char_t  due_chars[$];
    logic [7:0]  model_store[LINE_DEPTH];
    int          model_fill   = 0;
    logic        model_enable = 1'b1;

    int          mismatches   = 0;
    int          chars_sent   = 0;
    int          burst_left   = 0;
    bit          gaps_on      = 1'b0;
    ready_mode_t ready_mode   = RDY_ALWAYS;
    int          hold_request = 0;
    int          hold_served  = 0;
    int          stall_left   = 0;
    int          rx_phase     = 0;
    int          quiet_cycles = 0;
    line_char_t  seen_char;
    line_char_t  want_char;

    serial_line_assembler_unit #(
        .LINE_DEPTH(LINE_DEPTH)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .line_byte  (line_byte),
        .line_length(line_length),
        .is_last    (is_last)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void edit_line(input logic [7:0] ch);
        if (!model_enable)
            return;
        if (ch == CH_CR || ch == CH_LF)
        begin
            if (model_fill > 0)
            begin
                for (int k = 0; k < model_fill; k++)
                    due_chars.push_back('{ch: model_store[k], len: 6'(model_fill),
                                          last: (k + 1 == model_fill)});
                model_fill = 0;
            end
        end
        else if (ch == CH_BS || ch == CH_DEL)
        begin
            if (model_fill > 0)
                model_fill--;
        end
        else if (model_fill < LINE_DEPTH - 1)
        begin
            model_store[model_fill] = ch;
            model_fill++;
        end
    endfunction

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(0, 255));
        while (c == CH_CR || c == CH_LF || c == CH_BS || c == CH_DEL);
        return c;
    endfunction

    function automatic void flag_mismatch(input string what, input line_char_t want,
                                          input line_char_t got);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch (%s): expected byte %02h len %0d last %0b,",
                     what, want.ch, want.len, want.last,
                     " got byte %02h len %0d last %0b", got.ch, got.len, got.last);
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int gap;
        if (gaps_on && burst_left == 0)
        begin
            gap = $urandom_range(1, 6);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(1, 10);
        end
        if (burst_left > 0)
            burst_left--;
        in_valid <= 1'b1;
        rx_byte  <= ch;
        do
            @(posedge clk);
        while (!in_ready);
        chars_sent++;
        edit_line(ch);
    endtask

    task automatic quiesce();
        in_valid <= 1'b0;
        while (due_chars.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_line_enable(input logic value);
        quiesce();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_LINE_ENABLE;
        pwdata  <= {31'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        model_enable = value;
    endtask

    task automatic test_directed_edits();
        send_char("A");
        send_char(CH_CR);
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_BS);
        send_char(CH_DEL);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(8'h80);
        send_char(8'h7E);
        send_char(8'h09);
        send_char(8'h0B);
        send_char(8'h0C);
        send_char(8'h0E);
        send_char(CH_BS);
        send_char(8'h55);
        send_char(CH_DEL);
        send_char(8'hAA);
        send_char(CH_LF);
        send_char("x");
        send_char("y");
        send_char(CH_CR);
        send_char(CH_LF);
    endtask

    task automatic test_line_overflow();
        repeat (LINE_DEPTH + 2) send_char(text_char());
        send_char(CH_CR);
        repeat (LINE_DEPTH + 2) send_char(text_char());
        send_char(CH_DEL);
        send_char(text_char());
        send_char(CH_LF);
    endtask

    task automatic test_disabled_assembly();
        send_char("a");
        send_char("b");
        set_line_enable(1'b0);
        repeat (12) send_char(8'($urandom_range(0, 255)));
        send_char(CH_CR);
        send_char(CH_LF);
        send_char(CH_BS);
        send_char(CH_DEL);
        set_line_enable(1'b1);
        send_char("c");
        send_char(CH_LF);
    endtask

    task automatic test_receiver_hold();
        hold_request <= hold_request + 1;
        repeat (20) send_char(text_char());
        send_char(CH_LF);
        repeat (10) send_char(text_char());
        send_char(CH_CR);
        repeat (5) send_char(text_char());
        send_char(CH_LF);
        quiesce();
    endtask

    task automatic test_random_lines();
        int base;
        int kind;
        int len;
        base = chars_sent;
        for (int ph = 0; ph < 4; ph++)
        begin
            ready_mode <= ready_mode_t'(ph % 3);
            gaps_on = (ph != 1);
            do
            begin
                kind = $urandom_range(0, 9);
                if (kind == 0)
                    send_char(8'($urandom_range(0, 255)));
                else if (kind == 1)
                begin
                    repeat ($urandom_range(1, 5)) send_char(text_char());
                    repeat ($urandom_range(2, 8))
                        send_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
                    if ($urandom_range(0, 1))
                        send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
                else
                begin
                    len = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 70)
                                                       : $urandom_range(1, 12);
                    for (int k = 0; k < len; k++)
                    begin
                        if ($urandom_range(0, 7) == 0)
                            send_char($urandom_range(0, 1) ? CH_BS : CH_DEL);
                        else
                            send_char(text_char());
                    end
                    send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
                end
            end
            while (chars_sent - base < (RANDOM_ITEMS / 4) * (ph + 1));
        end
        send_char(text_char());
        send_char(CH_LF);
    endtask

    always @(posedge clk)
    begin
        rx_phase <= rx_phase + 1;
        if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_served != hold_request)
        begin
            hold_served <= hold_request;
            stall_left  <= HOLD_LEN - 1;
            out_ready   <= 1'b0;
        end
        else
        begin
            case (ready_mode)
                RDY_RANDOM:  out_ready <= ($urandom_range(0, 99) < 60);
                RDY_PATTERN: out_ready <= ((rx_phase % 7) > 2);
                default:     out_ready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            seen_char = '{ch: line_byte, len: line_length, last: is_last};
            if (due_chars.size() == 0)
                flag_mismatch("no line pending", '0, seen_char);
            else
            begin
                want_char = due_chars.pop_front();
                if (seen_char !== want_char)
                    flag_mismatch("line character", want_char, seen_char);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (psel && penable && pready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb_serial_line_assembler_unit: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        set_line_enable(1'b1);
        test_directed_edits();
        gaps_on = 1'b1;
        ready_mode <= RDY_RANDOM;
        test_line_overflow();
        test_disabled_assembly();
        test_receiver_hold();
        test_random_lines();
        in_valid <= 1'b0;
        while (due_chars.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (mismatches == 0)
            $display("tb_serial_line_assembler_unit: clean");
        else
            $display("tb_serial_line_assembler_unit: errors");
        $finish;
    end

endmodule
